[design/np_pkg.sv]
// Package with the request types, state encoding and fixed widths of next_permutation.
package np_pkg;

    localparam int VAL_W = 16;

    typedef struct packed {
        logic [VAL_W-1:0] elem_value;
        logic             is_last_elem;
    } np_in_t;

    typedef struct packed {
        logic [VAL_W-1:0] out_value;
        logic             out_last;
        logic             wrapped;
        logic             overflowed;
    } np_out_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_FIND_RD,
        ST_FIND_CMP,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_REV_RD,
        ST_REV_WA,
        ST_REV_WB,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } np_state_t;

endpackage

[design/next_permutation.sv]
// Top level of next_permutation: sequence store, permutation sequencer and result register.
//
//  channel | direction | payload  | handshake
//  in      | input     | np_in_t  | in_valid / in_stall
//  out     | output    | np_out_t | out_valid / out_stall
//
// Loading accepts one element per cycle. After the marked element the sequencer works on a
// single-write, dual-read store: it reads and compares each pair in the ascent scan and each
// element in the larger-element search, writes the swap and each reversed suffix pair one end
// at a time on the single write port, and reads then emits each element, holding on out_stall.
// in_stall is high from the marked request until the last result sits in the output register.
// Reset clears the sequencer, the load count, the overflow flag and the output valid.
module next_permutation #(
    parameter int MAX_LEN    = 16,
    parameter int ELEM_WIDTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  np_pkg::np_in_t  in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output np_pkg::np_out_t out_data
);
    import np_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [ELEM_WIDTH-1:0] mem [MAX_LEN];
    logic [ELEM_WIDTH-1:0] rd0_reg, rd1_reg;

    np_state_t state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  ovf_reg, ovf_next;
    logic                  wrap_reg, wrap_next;
    logic [AW-1:0]         idx_a_reg, idx_a_next;
    logic [AW-1:0]         idx_b_reg, idx_b_next;
    logic [AW-1:0]         last_reg, last_next;
    logic [ELEM_WIDTH-1:0] piv_reg, piv_next;
    logic                  out_valid_reg, out_valid_next;
    np_out_t               out_reg, out_next;

    logic                  we;
    logic [AW-1:0]         wa;
    logic [ELEM_WIDTH-1:0] wd;

    logic                    in_acc;
    logic                    full;
    logic [CW-1:0]           n_acc;
    logic [ELEM_WIDTH+15:0]  in_ext;
    logic [ELEM_WIDTH+15:0]  rd_ext;
    logic                    slot_free;

    assign in_acc    = in_valid && !in_stall;
    assign full      = (cnt_reg == CW'(MAX_LEN));
    assign n_acc     = full ? cnt_reg : cnt_reg + CW'(1);
    assign in_ext    = {{ELEM_WIDTH{1'b0}}, in_data.elem_value};
    assign rd_ext    = {16'b0, rd0_reg};
    assign slot_free = !out_valid_reg || !out_stall;

    assign in_stall  = (state_reg != ST_LOAD);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd0_reg <= mem[idx_a_reg];
        rd1_reg <= mem[idx_b_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wrap_reg  <= wrap_next;
        idx_a_reg <= idx_a_next;
        idx_b_reg <= idx_b_next;
        last_reg  <= last_next;
        piv_reg   <= piv_next;
        out_reg   <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        wrap_next      = wrap_reg;
        idx_a_next     = idx_a_reg;
        idx_b_next     = idx_b_reg;
        last_next      = last_reg;
        piv_next       = piv_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        we             = 1'b0;
        wa             = idx_a_reg;
        wd             = rd1_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        we       = 1'b1;
                        wa       = cnt_reg[AW-1:0];
                        wd       = in_ext[ELEM_WIDTH-1:0];
                        cnt_next = n_acc;
                    end
                    if (in_data.is_last_elem)
                    begin
                        wrap_next  = 1'b0;
                        last_next  = AW'(n_acc - CW'(1));
                        idx_b_next = AW'(n_acc - CW'(1));
                        if (n_acc == CW'(1))
                        begin
                            idx_a_next = '0;
                            state_next = ST_EMIT_RD;
                        end
                        else
                        begin
                            idx_a_next = AW'(n_acc - CW'(2));
                            state_next = ST_SCAN_RD;
                        end
                    end
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                if (rd0_reg < rd1_reg)
                begin
                    piv_next   = rd0_reg;
                    idx_b_next = last_reg;
                    state_next = ST_FIND_RD;
                end
                else if (idx_a_reg == '0)
                begin
                    wrap_next  = 1'b1;
                    idx_b_next = last_reg;
                    state_next = ST_REV_RD;
                end
                else
                begin
                    idx_a_next = idx_a_reg - AW'(1);
                    idx_b_next = idx_b_reg - AW'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_FIND_RD:
            begin
                state_next = ST_FIND_CMP;
            end
            ST_FIND_CMP:
            begin
                if (rd1_reg > piv_reg)
                begin
                    state_next = ST_SWAP_A;
                end
                else
                begin
                    idx_b_next = idx_b_reg - AW'(1);
                    state_next = ST_FIND_RD;
                end
            end
            ST_SWAP_A:
            begin
                we         = 1'b1;
                wa         = idx_a_reg;
                wd         = rd1_reg;
                state_next = ST_SWAP_B;
            end
            ST_SWAP_B:
            begin
                we         = 1'b1;
                wa         = idx_b_reg;
                wd         = piv_reg;
                idx_a_next = idx_a_reg + AW'(1);
                idx_b_next = last_reg;
                state_next = ST_REV_RD;
            end
            ST_REV_RD:
            begin
                if (idx_a_reg < idx_b_reg)
                begin
                    state_next = ST_REV_WA;
                end
                else
                begin
                    idx_a_next = '0;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_REV_WA:
            begin
                we         = 1'b1;
                wa         = idx_a_reg;
                wd         = rd1_reg;
                state_next = ST_REV_WB;
            end
            ST_REV_WB:
            begin
                we         = 1'b1;
                wa         = idx_b_reg;
                wd         = rd0_reg;
                idx_a_next = idx_a_reg + AW'(1);
                idx_b_next = idx_b_reg - AW'(1);
                state_next = ST_REV_RD;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.out_value  = rd_ext[VAL_W-1:0];
                    out_next.out_last   = (idx_a_reg == last_reg);
                    out_next.wrapped    = wrap_reg;
                    out_next.overflowed = ovf_reg;
                    if (idx_a_reg == last_reg)
                    begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        idx_a_next = idx_a_reg + AW'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

[design/np_checker.sv]
// Port-level assertion checker for next_permutation and its bind.
module np_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_stall,
    input np_pkg::np_in_t  in_data,
    input logic            out_valid,
    input logic            out_stall,
    input np_pkg::np_out_t out_data
);
    import np_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.is_last_elem |=> in_stall)
        else $error("input taken right after a marked request");

    a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.out_last |-> in_stall)
        else $error("input taken while a sequence is still being emitted");

    a_flags_const: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.out_last |=>
            !out_valid ||
            (out_data.wrapped == $past(out_data.wrapped) &&
             out_data.overflowed == $past(out_data.overflowed)))
        else $error("sequence flags changed within one permutation");

endmodule

bind next_permutation np_checker u_np_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
